>>> design/maf_pkg.sv
// Package for the boxcar moving-average filter: sizes, action and register
// codes, shared structs and the running-sum saturation function.
// No dependencies.
package maf_pkg;

   localparam int WINDOW_MAX    = 256;
   localparam int SAMPLE_BITS   = 16;
   localparam int POS_BITS      = $clog2(WINDOW_MAX);
   localparam int WIN_BITS      = $clog2(WINDOW_MAX + 1);
   localparam int SUM_BITS      = 25;
   localparam int AVG_BITS      = 24;
   localparam int FRAC_BITS     = 8;
   localparam int PROD_BITS     = AVG_BITS + WIN_BITS + 1;
   localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
   localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
   localparam int CSR_IDX_BITS  = 1;
   localparam int CSR_DATA_BITS = 16;
   localparam int WL_BITS       = 9;

   typedef enum logic [1:0] {
      ACT_STEP      = 2'd0,
      ACT_PREVIEW   = 2'd1,
      ACT_STORE_AVG = 2'd2,
      ACT_RESTART   = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 1'b0,
      CSR_INIT_VALUE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                          rd_en;
      logic                          wr_en;
      logic                          clear;
      logic [POS_BITS-1:0]           addr;
      logic signed [SAMPLE_BITS-1:0] wr_data;
   } ring_ctrl_type;

   typedef struct packed {
      logic                     start;
      logic                     negative;
      logic [DIVIDEND_BITS-1:0] magnitude;
      logic [WIN_BITS-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [AVG_BITS-1:0] quotient;
   } div_rsp_type;

   function automatic logic signed [SUM_BITS-1:0] sat_sum(
      input logic signed [PROD_BITS-1:0] v
   );
      logic signed [PROD_BITS-1:0] hi;
      logic signed [PROD_BITS-1:0] lo;
      hi = PROD_BITS'((64'sd1 <<< (SUM_BITS - 1)) - 64'sd1);
      lo = -hi - PROD_BITS'(1);
      if (v > hi) begin
         return SUM_BITS'(hi);
      end else if (v < lo) begin
         return SUM_BITS'(lo);
      end
      return SUM_BITS'(v);
   endfunction

endpackage

>>> design/maf_ring.sv
// Sample ring: 256 x 16 memory with registered read, plus per-entry
// written flags cleared by reset or restart. Depends on maf_pkg.
module maf_ring import maf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  ring_ctrl_type                 ctrl,
   output logic signed [SAMPLE_BITS-1:0] rd_data,
   output logic                          rd_written
);

   logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]         written_ff;
   logic [WINDOW_MAX-1:0]         written_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_written_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.addr];
      end
   end

   always_comb begin
      written_in = written_ff;
      if (ctrl.clear) begin
         written_in = '0;
      end else if (ctrl.wr_en) begin
         written_in[ctrl.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff <= written_in;
         if (ctrl.rd_en) begin
            rd_written_ff <= written_ff[ctrl.addr];
         end
      end
   end

   assign rd_data    = rd_data_ff;
   assign rd_written = rd_written_ff;

endmodule

>>> design/maf_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle, with sign
// restore and saturation to the 24-bit average range. Depends on maf_pkg.
module maf_divider import maf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [WIN_BITS-1:0]      rem_ff, rem_in;
   logic [WIN_BITS-1:0]      dvs_ff, dvs_in;
   logic                     neg_ff, neg_in;
   logic [WIN_BITS:0]        cand;
   logic                     qbit;
   logic [AVG_BITS-1:0]      pos_max;
   logic [AVG_BITS-1:0]      neg_min;

   assign cand = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign qbit = (cand >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_BITS'(DIVIDEND_BITS);
         quo_in  = req.magnitude;
         rem_in  = '0;
         dvs_in  = req.divisor;
         neg_in  = req.negative;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], qbit};
         rem_in = qbit ? WIN_BITS'(cand - {1'b0, dvs_ff}) : WIN_BITS'(cand);
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign pos_max = {1'b0, {(AVG_BITS-1){1'b1}}};
   assign neg_min = {1'b1, {(AVG_BITS-1){1'b0}}};

   always_comb begin
      rsp.done = done_ff;
      if (neg_ff) begin
         if (quo_ff >= DIVIDEND_BITS'(neg_min)) begin
            rsp.quotient = signed'(neg_min);
         end else begin
            rsp.quotient = signed'(AVG_BITS'(-quo_ff[AVG_BITS-1:0]));
         end
      end else begin
         if (quo_ff > DIVIDEND_BITS'(pos_max)) begin
            rsp.quotient = signed'(pos_max);
         end else begin
            rsp.quotient = signed'(quo_ff[AVG_BITS-1:0]);
         end
      end
   end

endmodule

>>> design/moving_average_filter.sv
// Top level of the boxcar moving-average filter: handshakes, registers,
// sequencer and running sum. Depends on maf_pkg, maf_ring, maf_divider.
//
// An item passes from transfer to result through ST_FETCH, which fetches the
// oldest ring entry and forms the window product, ST_SUM, which updates the
// running sum, ST_DIV, in which the bit-serial divider computes (sum << 8) / window
// (33 quotient bits), and ST_RESP, which hands over the result. The
// divider sets the rate. req_stall is high while an item is in flight; a finished
// result waits in the output register without blocking the next transfer.
// window_length is clamped to 2..256; change it only together with a restart.
module moving_average_filter import maf_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_action,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic signed [AVG_BITS-1:0]    req_given_average,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [AVG_BITS-1:0]    rsp_average_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_data
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_SUM   = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [WL_BITS-1:0]            wl_ff;
   logic signed [SAMPLE_BITS-1:0] init_ff;
   logic [POS_BITS-1:0]           pos_ff, pos_in;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   action_type                    action_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [AVG_BITS-1:0]    given_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [AVG_BITS-1:0]    avg_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [AVG_BITS-1:0]    rsp_data_ff;

   logic [WIN_BITS-1:0]           win;
   logic [WIN_BITS-1:0]           pos_inc;
   logic [POS_BITS-1:0]           pos_adv;
   logic signed [AVG_BITS-1:0]    mul_a;
   logic signed [WIN_BITS:0]      win_s;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic                          rd_written;
   logic signed [SAMPLE_BITS-1:0] oldest;
   logic signed [SUM_BITS+1:0]    acc;
   logic signed [PROD_BITS-1:0]   prod_scaled;
   logic signed [SUM_BITS-1:0]    sum_new;
   logic [SUM_BITS-1:0]           sum_mag;
   logic                          req_take;
   logic                          rsp_load;
   ring_ctrl_type                 ring_ctrl;
   div_req_type                   div_req;
   div_rsp_type                   div_rsp;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff   <= WL_BITS'(16);
         init_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LENGTH: wl_ff   <= csr_data[WL_BITS-1:0];
            CSR_INIT_VALUE:    init_ff <= signed'(csr_data[SAMPLE_BITS-1:0]);
            default: ;
         endcase
      end
   end

   always_comb begin
      win = wl_ff;
      if (wl_ff < WIN_BITS'(2)) begin
         win = WIN_BITS'(2);
      end else if (wl_ff > WIN_BITS'(WINDOW_MAX)) begin
         win = WIN_BITS'(WINDOW_MAX);
      end
   end

   assign pos_inc = {1'b0, pos_ff} + WIN_BITS'(1);
   assign pos_adv = (pos_inc >= win) ? '0 : pos_inc[POS_BITS-1:0];

   assign mul_a = (action_ff == ACT_STORE_AVG) ? given_ff : AVG_BITS'(init_ff);
   assign win_s = signed'({1'b0, win});

   assign oldest      = rd_written ? rd_data : init_ff;
   assign acc         = (SUM_BITS+2)'(sum_ff) + (SUM_BITS+2)'(sample_ff)
                        - (SUM_BITS+2)'(oldest);
   assign prod_scaled = (prod_ff < 0) ? ((prod_ff + PROD_BITS'(255)) >>> FRAC_BITS)
                                      : (prod_ff >>> FRAC_BITS);

   always_comb begin
      unique case (action_ff)
         ACT_STEP, ACT_PREVIEW: sum_new = sat_sum(PROD_BITS'(acc));
         ACT_STORE_AVG:         sum_new = sat_sum(prod_scaled);
         ACT_RESTART:           sum_new = sat_sum(prod_ff);
         default:               sum_new = sum_ff;
      endcase
   end

   assign sum_mag = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);

   assign rsp_load = (state_ff == ST_RESP) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      ring_ctrl         = '0;
      ring_ctrl.addr    = pos_ff;
      ring_ctrl.wr_data = sample_ff;
      div_req           = '0;
      div_req.negative  = sum_new[SUM_BITS-1];
      div_req.magnitude = {sum_mag, {FRAC_BITS{1'b0}}};
      div_req.divisor   = win;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            ring_ctrl.rd_en = 1'b1;
            state_in        = ST_SUM;
         end
         ST_SUM: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV;
            if (action_ff != ACT_PREVIEW) begin
               sum_in = sum_new;
            end
            if (action_ff == ACT_STEP || action_ff == ACT_STORE_AVG) begin
               ring_ctrl.wr_en = 1'b1;
               pos_in          = pos_adv;
            end
            if (action_ff == ACT_RESTART) begin
               ring_ctrl.clear = 1'b1;
               pos_in          = '0;
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff <= action_type'(req_action);
         sample_ff <= req_sample;
         given_ff  <= req_given_average;
      end
      if (state_ff == ST_FETCH) begin
         prod_ff <= PROD_BITS'(mul_a) * PROD_BITS'(win_s);
      end
      if (div_rsp.done) begin
         avg_ff <= div_rsp.quotient;
      end
      if (rsp_load) begin
         rsp_data_ff <= avg_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_average_out = rsp_data_ff;

   maf_ring u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ring_ctrl),
      .rd_data    (rd_data),
      .rd_written (rd_written)
   );

   maf_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

endmodule

>>> design/maf_checker.sv
// Port-level checker for the moving-average filter, bound to the top level.
// Depends on maf_pkg.
module maf_checker import maf_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic [1:0]                    req_action,
   input logic signed [SAMPLE_BITS-1:0] req_sample,
   input logic signed [AVG_BITS-1:0]    req_given_average,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [AVG_BITS-1:0]    rsp_average_out
);

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after transfer");

   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after transfer");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_stall) |=>
         (req_valid && $stable({req_action, req_sample, req_given_average})))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_average_out)))
      else $error("stalled result changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("outputs not idle after reset");

endmodule

bind moving_average_filter maf_checker u_checker (.*);

>>> sim/tb_top.sv
// Self-checking testbench for moving_average_filter: a directed table and then random
// episodes, each checked against a predictor of the window sum and the average.
// Depends on maf_pkg and the moving_average_filter RTL.
module tb_top;
   import maf_pkg::*;

   typedef struct {
      bit                            set_window;
      logic [WL_BITS-1:0]            window;
      bit                            set_init;
      logic signed [SAMPLE_BITS-1:0] init;
      action_type                    act;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic signed [AVG_BITS-1:0]    ga;
      bit                            typed;
      logic signed [AVG_BITS-1:0]    avg;
   } script_row_type;

   localparam longint FRAC_SCALE = 64'sd1 <<< FRAC_BITS;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [1:0]                    req_action;
   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic signed [AVG_BITS-1:0]    req_given_average;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic signed [AVG_BITS-1:0]    rsp_average_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_IDX_BITS-1:0]       csr_index;
   logic [CSR_DATA_BITS-1:0]      csr_data;

   // predictor state
   logic signed [SAMPLE_BITS-1:0] window_samples [WINDOW_MAX];
   bit                            slot_filled [WINDOW_MAX];
   int unsigned                   fill_pos;
   longint                        window_sum;
   logic [WL_BITS-1:0]            cfg_window;
   logic signed [SAMPLE_BITS-1:0] cfg_init;

   logic signed [AVG_BITS-1:0]    expected_averages [$];

   int sender_idle_pct;
   int stall_pct;
   int items_sent;
   int results_checked;
   int error_count;
   int register_writes;
   int action_count [4];

   script_row_type directed_script [24] = '{
      '{0, 9'd0,   0, 16'sd0,     ACT_PREVIEW,   16'sd0,     24'sd0,      1, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh7FFF,  24'sd0,      1, 24'sd524272},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh8000,  24'sd0,      1, -24'sd16},
      '{0, 9'd0,   0, 16'sd0,     ACT_PREVIEW,   16'sh7FFF,  24'sh7FFFFF, 0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sd1,     24'sh800000, 0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STORE_AVG, -16'sd1,    24'sh7FFFFF, 0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STORE_AVG, 16'sd0,     24'sh800000, 1, 24'sh800000},
      '{0, 9'd0,   0, 16'sd0,     ACT_STORE_AVG, 16'sh7FFF,  -24'sd1,     1, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_RESTART,   16'sh8000,  24'sd0,      1, 24'sd0},
      '{1, 9'd0,   1, 16'sh8000,  ACT_RESTART,   16'sh7FFF,  24'sh7FFFFF, 1, 24'sh800000},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh7FFF,  24'sd0,      1, -24'sd128},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh7FFF,  24'sd0,      0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh8000,  24'sd0,      0, 24'sd0},
      '{1, 9'd511, 1, 16'sh7FFF,  ACT_RESTART,   16'sd0,     24'sd0,      1, 24'sd8388352},
      '{0, 9'd0,   0, 16'sd0,     ACT_PREVIEW,   16'sh8000,  24'sd0,      0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh8000,  24'sd0,      0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sd0,     24'sd0,      0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sd100,   24'sd0,      0, 24'sd0},
      '{1, 9'd1,   0, 16'sd0,     ACT_STEP,      16'sd5,     24'sd0,      0, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_PREVIEW,   16'sh8000,  24'sd0,      0, 24'sd0},
      '{1, 9'd256, 1, 16'sd0,     ACT_RESTART,   16'sd0,     24'sd0,      1, 24'sd0},
      '{0, 9'd0,   0, 16'sd0,     ACT_STORE_AVG, 16'sh7FFF,  24'sh7FFFFF, 1, 24'sh7FFFFF},
      '{0, 9'd0,   0, 16'sd0,     ACT_STEP,      16'sh8000,  24'sd0,      0, 24'sd0},
      '{1, 9'd16,  0, 16'sd0,     ACT_RESTART,   16'sd0,     24'sd0,      1, 24'sd0}
   };

   moving_average_filter i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_sample        (req_sample),
      .req_given_average (req_given_average),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_average_out   (rsp_average_out),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint saturate(longint v, int bits);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic longint active_window();
      longint w;
      w = longint'(cfg_window);
      if (w < 2) w = 2;
      if (w > WINDOW_MAX) w = WINDOW_MAX;
      return w;
   endfunction

   function automatic logic signed [AVG_BITS-1:0] average_of_sum(longint s);
      return AVG_BITS'(saturate((s * FRAC_SCALE) / active_window(), AVG_BITS));
   endfunction

   function automatic void store_sample(logic signed [SAMPLE_BITS-1:0] smp);
      int unsigned p;
      p = (fill_pos < WINDOW_MAX) ? fill_pos : 0;
      window_samples[p] = smp;
      slot_filled[p] = 1'b1;
      p++;
      if (longint'(p) >= active_window()) p = 0;
      fill_pos = p;
   endfunction

   // Updates the predictor state (except for a preview) and returns the average the block should report.
   function automatic logic signed [AVG_BITS-1:0] filter_update(
      action_type act, logic signed [SAMPLE_BITS-1:0] smp, logic signed [AVG_BITS-1:0] ga
   );
      int unsigned p;
      longint oldest_val;
      p = (fill_pos < WINDOW_MAX) ? fill_pos : 0;
      oldest_val = slot_filled[p] ? longint'(window_samples[p]) : longint'(cfg_init);
      case (act)
         ACT_STEP: begin
            window_sum = saturate(window_sum + longint'(smp) - oldest_val, SUM_BITS);
            store_sample(smp);
            return average_of_sum(window_sum);
         end
         ACT_PREVIEW: begin
            return average_of_sum(
               saturate(window_sum + longint'(smp) - oldest_val, SUM_BITS));
         end
         ACT_STORE_AVG: begin
            window_sum = saturate((longint'(ga) * active_window()) / FRAC_SCALE, SUM_BITS);
            store_sample(smp);
            return average_of_sum(window_sum);
         end
         default: begin
            foreach (slot_filled[i]) slot_filled[i] = 1'b0;
            fill_pos = 0;
            window_sum = saturate(longint'(cfg_init) * active_window(), SUM_BITS);
            return average_of_sum(window_sum);
         end
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
      case ($urandom_range(0, 7))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return SAMPLE_BITS'($urandom_range(0, 31)) - 16'sd16;
         default: return SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic signed [AVG_BITS-1:0] random_given_average();
      case ($urandom_range(0, 7))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return AVG_BITS'($urandom_range(0, 511)) - 24'sd256;
         default: return AVG_BITS'($urandom);
      endcase
   endfunction

   function automatic action_type random_action();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return ACT_STEP;
      if (r < 75) return ACT_PREVIEW;
      if (r < 88) return ACT_STORE_AVG;
      return ACT_RESTART;
   endfunction

   task automatic send_item(action_type act, logic signed [SAMPLE_BITS-1:0] smp,
                            logic signed [AVG_BITS-1:0] ga, bit typed,
                            logic signed [AVG_BITS-1:0] typed_avg);
      logic signed [AVG_BITS-1:0] predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_sample        <= smp;
      req_given_average <= ga;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = filter_update(act, smp, ga);
      expected_averages.push_back(typed ? typed_avg : predicted);
      items_sent++;
      action_count[act]++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      drain_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_WINDOW_LENGTH) cfg_window = data[WL_BITS-1:0];
      else cfg_init = data;
      register_writes++;
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] window_word(logic [WL_BITS-1:0] w);
      return {7'($urandom_range(0, 127)), w};
   endfunction

   // Pushes the running sum past its range: restart at one extreme, flip init_value to
   // the other, then keep feeding the first extreme over the unwritten entries.
   task automatic run_sum_drift();
      logic signed [SAMPLE_BITS-1:0] start_level;
      int i;
      start_level = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      write_register(CSR_WINDOW_LENGTH, window_word(9'd256));
      write_register(CSR_INIT_VALUE, start_level);
      send_item(ACT_RESTART, random_sample(), random_given_average(), 1'b0, '0);
      write_register(CSR_INIT_VALUE, ~start_level);
      for (i = 0; i < 160; i++) begin
         send_item(($urandom_range(0, 7) == 0) ? ACT_PREVIEW : ACT_STEP, start_level,
                   random_given_average(), 1'b0, '0);
      end
      // shrink without restart: stale position and saturated average
      write_register(CSR_WINDOW_LENGTH, window_word(WL_BITS'($urandom_range(0, 8))));
      for (i = 0; i < 10; i++) begin
         send_item(random_action(), random_sample(), random_given_average(), 1'b0, '0);
      end
   endtask

   task automatic reconfigure();
      logic [WL_BITS-1:0] w;
      logic signed [SAMPLE_BITS-1:0] iv;
      int which;
      case ($urandom_range(0, 9))
         0: w = WL_BITS'($urandom_range(0, 1));
         1: w = 9'd256;
         2: w = WL_BITS'($urandom_range(257, 511));
         3, 4, 5, 6: w = WL_BITS'($urandom_range(2, 12));
         default: w = WL_BITS'($urandom_range(2, 256));
      endcase
      iv = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000)
                                       : SAMPLE_BITS'($urandom);
      which = $urandom_range(0, 2);
      if (which != 1) write_register(CSR_WINDOW_LENGTH, window_word(w));
      if (which != 0) write_register(CSR_INIT_VALUE, iv);
      if ($urandom_range(0, 3) != 0) begin
         send_item(ACT_RESTART, random_sample(), random_given_average(), 1'b0, '0);
      end
   endtask

   task automatic run_phase(int idle, int stall, int n_items);
      int target;
      int n;
      int i;
      drain_results();
      sender_idle_pct = idle;
      stall_pct       = stall;
      target          = items_sent + n_items;
      run_sum_drift();
      while (items_sent < target) begin
         if ($urandom_range(0, 7) == 0) begin
            reconfigure();
         end else begin
            n = $urandom_range(5, 40);
            for (i = 0; i < n; i++) begin
               send_item(random_action(), random_sample(), random_given_average(), 1'b0, '0);
            end
         end
      end
   endtask

   always @(posedge clock) begin : rsp_check
      logic signed [AVG_BITS-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (expected_averages.size() == 0) begin
               $display("%0t: unexpected result transfer, got %0d", $time, rsp_average_out);
               error_count++;
            end else begin
               want = expected_averages.pop_front();
               if (rsp_average_out !== want) begin
                  $display("%0t: average_out mismatch, expected %0d, got %0d",
                           $time, want, rsp_average_out);
                  error_count++;
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_action        = ACT_STEP;
      req_sample        = '0;
      req_given_average = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_WINDOW_LENGTH;
      csr_data          = '0;
      sender_idle_pct   = 0;
      stall_pct         = 0;
      items_sent        = 0;
      results_checked   = 0;
      error_count       = 0;
      register_writes   = 0;
      foreach (action_count[i]) action_count[i] = 0;
      foreach (slot_filled[i]) slot_filled[i] = 1'b0;
      fill_pos   = 0;
      window_sum = 0;
      cfg_window = 9'd16;
      cfg_init   = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_script[i]) begin
         if (directed_script[i].set_window) begin
            write_register(CSR_WINDOW_LENGTH, window_word(directed_script[i].window));
         end
         if (directed_script[i].set_init) begin
            write_register(CSR_INIT_VALUE, directed_script[i].init);
         end
         send_item(directed_script[i].act, directed_script[i].smp, directed_script[i].ga,
                   directed_script[i].typed, directed_script[i].avg);
      end

      run_phase(0, 0, 450);
      run_phase(75, 0, 450);
      run_phase(0, 75, 450);
      run_phase(29, 29, 450);

      req_valid <= 1'b0;
      while (expected_averages.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Covered %0d transfers: %0d step, %0d preview, %0d store-average, %0d restart;",
               items_sent, action_count[ACT_STEP], action_count[ACT_PREVIEW],
               action_count[ACT_STORE_AVG], action_count[ACT_RESTART]);
      $display("%0d register writes, %0d averages checked, %0d mismatches.",
               register_writes, results_checked, error_count);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> files.f
design/maf_pkg.sv
design/maf_ring.sv
design/maf_divider.sv
design/moving_average_filter.sv
design/maf_checker.sv
sim/tb_top.sv
